// ===== design/assert_macros.svh =====
// Assertion helpers included by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define RCFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define RCFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfr_pkg
// Constants and types for the RC channel frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfr_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int CHANNELS    = 14;

    localparam int POS_W   = 6;
    localparam int ADDR_W  = 5;
    localparam int CHAN_W  = 4;
    localparam int VALUE_W = 16;
    localparam int TOL_W   = 10;
    localparam int IDX_W   = 8;

    localparam logic [7:0] START_BYTE  = 8'h20;
    localparam logic [7:0] SECOND_BYTE = 8'h40;
    localparam logic [15:0] SUM_BASE   = 16'hFFFF;

    localparam logic [IDX_W-1:0] REG_MIN_VALUE     = 8'd0;
    localparam logic [IDX_W-1:0] REG_MAX_VALUE     = 8'd1;
    localparam logic [IDX_W-1:0] REG_MID_VALUE     = 8'd2;
    localparam logic [IDX_W-1:0] REG_MID_TOLERANCE = 8'd3;

    localparam logic [VALUE_W-1:0] MIN_VALUE_RST = 16'd1000;
    localparam logic [VALUE_W-1:0] MAX_VALUE_RST = 16'd2000;
    localparam logic [VALUE_W-1:0] MID_VALUE_RST = 16'd1500;
    localparam logic [TOL_W-1:0]   MID_TOL_RST   = 10'd10;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CHAN_W-1:0] chan_t;

    localparam pos_t  POS_CKS_LO = pos_t'(FRAME_BYTES - 2);
    localparam pos_t  POS_CKS_HI = pos_t'(FRAME_BYTES - 1);
    localparam chan_t CHAN_LAST  = chan_t'(CHANNELS - 1);

endpackage

`default_nettype wire

// ===== design/rc_channel_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// rc_channel_frame_receiver
// Assembles serial bytes into a 32-byte frame, checks header and checksum,
// and streams out the clamped and centre-snapped channel values.
// ----------------------------------------------------------------------------
// Readout start: the last byte of a good frame sets SHAPE for channel 0.
// Throughput: one byte a cycle while collecting; readout steps each channel
//   through SHAPE (store read, shaped value registered) and SHOW (output
//   register), during which no byte is taken. Stalls on the output side hold SHOW.
// Reset: async, active low; clears position and registers to defaults. The
//   frame store is not cleared and needs no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module rc_channel_frame_receiver
    import rcfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,    // [7:0] rx_byte
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,    // [3:0] channel_index, [19:4] channel_value
    output logic                   m_tlast,    // last_channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [15:0]       cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHAPE = 2'd1;
    localparam logic [1:0] ST_SHOW  = 2'd2;

    logic [1:0]          state_reg, state_next;
    pos_t                pos_reg, pos_next;
    logic [15:0]         sum_reg, sum_next;
    logic [7:0]          cks_lo_reg, cks_lo_next;
    logic                second_ok_reg, second_ok_next;
    chan_t               chan_reg, chan_next;
    logic [VALUE_W-1:0]  value_reg, value_next;

    logic [VALUE_W-1:0]  min_value_reg;
    logic [VALUE_W-1:0]  max_value_reg;
    logic [VALUE_W-1:0]  mid_value_reg;
    logic [TOL_W-1:0]    mid_tol_reg;

    logic [7:0]          frame_mem [FRAME_BYTES];
    logic [7:0]          rd_lo_reg, rd_hi_reg;
    logic                wr_en;
    addr_t               wr_addr;
    addr_t               rd_addr_lo, rd_addr_hi;

    logic                in_acc, out_acc;
    logic [VALUE_W-1:0]  raw;
    logic [VALUE_W:0]    raw_ext, tol_ext, mid_ext;
    logic                in_band;
    logic [VALUE_W-1:0]  shaped;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg <= MIN_VALUE_RST;
            max_value_reg <= MAX_VALUE_RST;
            mid_value_reg <= MID_VALUE_RST;
            mid_tol_reg   <= MID_TOL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_VALUE:     min_value_reg <= cfg_data;
                REG_MAX_VALUE:     max_value_reg <= cfg_data;
                REG_MID_VALUE:     mid_value_reg <= cfg_data;
                REG_MID_TOLERANCE: mid_tol_reg   <= cfg_data[TOL_W-1:0];
                default:           ;
            endcase
        end
    end

    // Frame store: one write port, two registered read ports
    assign wr_addr    = pos_reg[ADDR_W-1:0];
    assign rd_addr_lo = addr_t'({chan_next, 1'b0} + 2);
    assign rd_addr_hi = addr_t'({chan_next, 1'b0} + 3);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= s_tdata;
        end
        rd_lo_reg <= frame_mem[rd_addr_lo];
        rd_hi_reg <= frame_mem[rd_addr_hi];
    end

    // Value shaping; the band test runs in 17 bits so nothing wraps
    assign raw     = {rd_hi_reg, rd_lo_reg};
    assign raw_ext = {1'b0, raw};
    assign tol_ext = {{(VALUE_W + 1 - TOL_W){1'b0}}, mid_tol_reg};
    assign mid_ext = {1'b0, mid_value_reg};
    assign in_band = ((raw_ext + tol_ext) > mid_ext) && (raw_ext < (mid_ext + tol_ext));

    always_comb
    begin
        if (raw < min_value_reg)
            shaped = min_value_reg;
        else if (raw > max_value_reg)
            shaped = max_value_reg;
        else if (in_band)
            shaped = mid_value_reg;
        else
            shaped = raw;
    end

    // Byte collection and readout sequencing
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        cks_lo_next    = cks_lo_reg;
        second_ok_next = second_ok_reg;
        chan_next      = chan_reg;
        value_next     = value_reg;
        wr_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tdata == START_BYTE)
                    begin
                        wr_en    = 1'b1;
                        pos_next = pos_t'(1);
                        sum_next = SUM_BASE - {8'd0, START_BYTE};
                    end
                    else if (pos_reg != '0)
                    begin
                        wr_en    = 1'b1;
                        pos_next = pos_reg + pos_t'(1);
                        if (pos_reg < POS_CKS_LO)
                            sum_next = sum_reg - {8'd0, s_tdata};
                        if (pos_reg == pos_t'(1))
                            second_ok_next = (s_tdata == SECOND_BYTE);
                        if (pos_reg == POS_CKS_LO)
                            cks_lo_next = s_tdata;
                        if (pos_reg == POS_CKS_HI)
                        begin
                            // close the frame, good or not
                            pos_next = '0;
                            if (second_ok_reg && (sum_reg == {s_tdata, cks_lo_reg}))
                            begin
                                chan_next  = '0;
                                state_next = ST_SHAPE;
                            end
                        end
                    end
                end
            end
            ST_SHAPE:
            begin
                value_next = shaped;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_acc)
                begin
                    if (chan_reg == CHAN_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        chan_next  = chan_reg + chan_t'(1);
                        state_next = ST_SHAPE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            chan_reg      <= '0;
            second_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            chan_reg      <= chan_next;
            second_ok_reg <= second_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        cks_lo_reg <= cks_lo_next;
        value_reg  <= value_next;
    end

    assign m_tvalid = (state_reg == ST_SHOW);
    assign m_tdata  = {4'd0, value_reg, chan_reg};
    assign m_tlast  = (chan_reg == CHAN_LAST);

    // Checks
    `RCFR_ASSERT(a_first_channel_zero,
        $fell(s_tready) |=> (m_tvalid && (m_tdata[3:0] == 4'd0)),
        "readout did not begin with channel zero")
    `RCFR_ASSERT(a_channel_step,
        (m_tvalid && m_tready && !m_tlast) |=> !m_tvalid ##1
            (m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0], 2) + 4'd1)),
        "channel index did not advance by one")
    `RCFR_ASSERT(a_last_ends_frame,
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready),
        "output continued after the last channel")
    `RCFR_ASSERT(a_no_overlap,
        !(s_tready && m_tvalid),
        "input taken while a channel word is pending")

endmodule

`default_nettype wire

// ===== dv/tb_rc_channel_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_rc_channel_frame_receiver
// Self-checking bench for the RC channel frame receiver. Frames of serial
// bytes, good and damaged, are streamed in with random bursts and gaps. A
// frame decoder in the bench predicts each channel word, and the words that
// come out under a shifting ready pattern are checked against it. Limit
// registers are reprogrammed between phases, including crossed and extreme
// settings.
// ----------------------------------------------------------------------------
module tb_rc_channel_frame_receiver;
    import rcfr_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 8'd4;
    localparam logic [IDX_W-1:0] REG_TOP    = 8'hFF;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_BYTES   = 8;

    typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_SUM} frame_flaw_t;

    typedef struct {
        logic [7:0] rx_byte;
        bit         hold;       // hold back until every channel word due has come
    } rx_item_t;

    typedef struct {
        chan_t              index;
        logic [VALUE_W-1:0] value;
        logic               last;
    } chan_word_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;   // [7:0] rx_byte
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [23:0]        m_tdata;             // [3:0] channel_index, [19:4] channel_value
    logic               m_tlast;             // last_channel
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [15:0]        cfg_data  = 16'h0000;

    // decoder state and register copies
    logic [7:0]         rx_frame [FRAME_BYTES] = '{default: 8'h00};
    pos_t               fill_pos   = '0;
    logic [VALUE_W-1:0] lim_lo     = MIN_VALUE_RST;
    logic [VALUE_W-1:0] lim_hi     = MAX_VALUE_RST;
    logic [VALUE_W-1:0] centre     = MID_VALUE_RST;
    logic [TOL_W-1:0]   centre_tol = MID_TOL_RST;

    rx_item_t   rx_pending [$];
    chan_word_t chan_due [$];
    rx_item_t   next_item;
    int         burst_left  = 0;
    int         gap_left    = 0;
    int         mismatches  = 0;
    int         idle_cycles = 0;
    int         stall_tick  = 0;
    logic [15:0] stall_pat  = 16'hA5A5;
    bit         ready_all   = 1'b1;

    rc_channel_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // frame decoder
    // ------------------------------------------------------------------
    function automatic logic [VALUE_W-1:0] shape_value(input logic [VALUE_W-1:0] raw);
        int band_lo;
        int band_hi;
        band_lo = int'(centre) - int'(centre_tol);
        band_hi = int'(centre) + int'(centre_tol);
        if (raw < lim_lo)
            return lim_lo;
        if (raw > lim_hi)
            return lim_hi;
        if (int'(raw) > band_lo && int'(raw) < band_hi)
            return centre;
        return raw;
    endfunction

    function automatic bit frame_passes();
        logic [15:0] sum;
        int i;
        if (rx_frame[0] != START_BYTE || rx_frame[1] != SECOND_BYTE)
            return 1'b0;
        sum = SUM_BASE;
        for (i = 0; i < FRAME_BYTES - 2; i++)
            sum = sum - 16'(rx_frame[i]);
        return sum == {rx_frame[FRAME_BYTES-1], rx_frame[FRAME_BYTES-2]};
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        chan_word_t w;
        int c;
        if (b == START_BYTE)
        begin
            rx_frame[0] = b;
            fill_pos = pos_t'(1);
        end
        else if (fill_pos != '0)
        begin
            rx_frame[fill_pos[ADDR_W-1:0]] = b;
            fill_pos = fill_pos + 1'b1;
        end
        if (fill_pos >= pos_t'(FRAME_BYTES))
        begin
            if (frame_passes())
            begin
                for (c = 0; c < CHANNELS; c++)
                begin
                    w.index = chan_t'(c);
                    w.value = shape_value({rx_frame[3 + 2*c], rx_frame[2 + 2*c]});
                    w.last  = (c == CHANNELS - 1);
                    chan_due.push_back(w);
                end
            end
            fill_pos = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b, input bit hold);
        rx_pending.push_back('{rx_byte: b, hold: hold});
    endfunction

    function automatic void push_frame(input logic [VALUE_W-1:0] vals [CHANNELS],
                                       input frame_flaw_t flaw, input bit hold);
        logic [7:0] fb [FRAME_BYTES];
        logic [15:0] sum;
        int i;
        fb[0] = START_BYTE;
        fb[1] = SECOND_BYTE;
        if (flaw == FLAW_HEADER)
        begin
            fb[1] = 8'($urandom);
            if (fb[1] == SECOND_BYTE || fb[1] == START_BYTE)
                fb[1] = SECOND_BYTE + 8'd1;
        end
        for (i = 0; i < CHANNELS; i++)
        begin
            fb[2 + 2*i] = vals[i][7:0];
            fb[3 + 2*i] = vals[i][15:8];
        end
        sum = SUM_BASE;
        for (i = 0; i < FRAME_BYTES - 2; i++)
            sum = sum - 16'(fb[i]);
        if (flaw == FLAW_SUM)
            sum = sum ^ (16'd1 << $urandom_range(0, 15));
        fb[FRAME_BYTES-2] = sum[7:0];
        fb[FRAME_BYTES-1] = sum[15:8];
        for (i = 0; i < FRAME_BYTES; i++)
            push_byte(fb[i], hold && (i == 0));
    endfunction

    // favour the clamp and snap boundaries of the current settings
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return lim_lo;
            1: return lim_lo - 16'd1;
            2: return lim_hi;
            3: return lim_hi + 16'd1;
            4: return centre;
            5: return centre - 16'(centre_tol);
            6: return centre + 16'(centre_tol);
            7: return centre - 16'(centre_tol) + 16'd1;
            8: return centre + 16'(centre_tol) - 16'd1;
            9: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void push_random_sequence(input bit force_hold);
        logic [VALUE_W-1:0] vals [CHANNELS];
        int c;
        int n;
        int kind;
        kind = $urandom_range(0, 9);
        for (c = 0; c < CHANNELS; c++)
        begin
            vals[c] = pick_value();
            // mostly keep the start byte out of the payload so frames complete
            if ($urandom_range(0, 9) != 0)
                while (vals[c][7:0] == START_BYTE || vals[c][15:8] == START_BYTE)
                    vals[c] = 16'($urandom);
        end
        case (kind)
            0:
            begin
                n = $urandom_range(1, 6);
                for (c = 0; c < n; c++)
                    push_byte(8'($urandom), 1'b0);
            end
            1:
            begin
                push_byte(START_BYTE, force_hold);
                push_byte(SECOND_BYTE, 1'b0);
                n = $urandom_range(0, 20);
                for (c = 0; c < n; c++)
                    push_byte(8'($urandom_range(START_BYTE + 1, 255)), 1'b0);
            end
            2: push_frame(vals, FLAW_HEADER, force_hold);
            3: push_frame(vals, FLAW_SUM, force_hold);
            default: push_frame(vals, FLAW_NONE, force_hold || $urandom_range(0, 6) == 0);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // register writes and phase control
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_VALUE:     lim_lo = val;
            REG_MAX_VALUE:     lim_hi = val;
            REG_MID_VALUE:     centre = val;
            REG_MID_TOLERANCE: centre_tol = val[TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] mid, input logic [15:0] tol);
        write_reg(REG_MIN_VALUE, lo);
        write_reg(REG_MAX_VALUE, hi);
        write_reg(REG_MID_VALUE, mid);
        write_reg(REG_MID_TOLERANCE, tol);
    endtask

    // hold until the sender is empty and every channel word has come, then settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (rx_pending.size() != 0 || s_tvalid || chan_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // byte driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (rx_pending.size() != 0 &&
                         !(rx_pending[0].hold && chan_due.size() != 0))
                begin
                    next_item = rx_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.rx_byte;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // channel word monitor
    // ------------------------------------------------------------------
    task automatic report(input string what, input int unsigned want, input int unsigned got);
        $display("mismatch at %0t: %s want 0x%0h got 0x%0h", $realtime, what, want, got);
        mismatches++;
    endtask

    task automatic check_word();
        chan_word_t want;
        if (chan_due.size() == 0)
        begin
            report("channel word with none due", 0, m_tdata);
            return;
        end
        want = chan_due.pop_front();
        if (m_tdata[3:0] !== want.index)
            report("channel_index", want.index, m_tdata[3:0]);
        if (m_tdata[19:4] !== want.value)
            report("channel_value", want.value, m_tdata[19:4]);
        if (m_tlast !== want.last)
            report("last_channel", want.last, m_tlast);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_word();
        stall_tick++;
        if (stall_tick % 97 == 0)
        begin
            stall_pat = 16'($urandom) | 16'h0001;
            ready_all = ($urandom_range(0, 3) == 0);
        end
        else
        begin
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
        m_tready <= ready_all || stall_pat[0];
    end

    // watchdog: give up when no word moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [VALUE_W-1:0] edge_vals [CHANNELS];
        logic [15:0] lo;
        logic [15:0] hi;
        int ph;

        edge_vals = '{16'd0, 16'd999, 16'd1000, 16'd1001, 16'd1490, 16'd1491, 16'd1499,
                      16'd1500, 16'd1509, 16'd1510, 16'd1999, 16'd2000, 16'd2001, 16'hFFFF};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: stray bytes, a good frame, a frame cut short by a restart,
        // then damaged header and damaged checksum
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(SECOND_BYTE, 1'b0);
        push_frame(edge_vals, FLAW_NONE, 1'b0);
        push_byte(START_BYTE, 1'b1);
        push_byte(SECOND_BYTE, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'hEE, 1'b0);
        push_frame(edge_vals, FLAW_NONE, 1'b0);
        push_frame(edge_vals, FLAW_HEADER, 1'b0);
        push_frame(edge_vals, FLAW_SUM, 1'b0);
        wait_drained();

        // crossed bounds, writes to unused indexes, tolerance bits above its width
        write_reg(REG_MIN_VALUE, 16'd2000);
        write_reg(REG_MAX_VALUE, 16'd1000);
        write_reg(REG_UNUSED, 16'h0000);
        write_reg(REG_TOP, 16'hFFFF);
        write_reg(REG_MID_TOLERANCE, 16'hFC05);
        write_reg(REG_MID_VALUE, 16'd1500);
        push_frame(edge_vals, FLAW_NONE, 1'b0);
        wait_drained();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_limits(16'h0000, 16'hFFFF, 16'h0000, 16'd1023);
                1: set_limits(16'h0000, 16'hFFFF, 16'hFFFF, 16'd1023);
                2:
                begin
                    lo = 16'($urandom_range(0, 30000));
                    hi = 16'($urandom_range(lo, 65535));
                    set_limits(lo, hi, 16'($urandom_range(lo, hi)), 16'd0);
                end
                3: set_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                default:
                begin
                    lo = 16'($urandom_range(0, 30000));
                    hi = 16'($urandom_range(lo, 65535));
                    set_limits(lo, hi, 16'($urandom_range(lo, hi)), 16'($urandom_range(0, 1023)));
                end
            endcase
            while (rx_pending.size() < PHASE_BYTES)
                push_random_sequence(ph == 0 && rx_pending.size() == 0);
            wait_drained();
        end

        if (mismatches == 0 && chan_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
